>>> src/rdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_pkg - shared types, constants and helpers for the radix digit formatter
// ----------------------------------------------------------------------------
// Field widths, register map, controller states, command and status
// structures, and the alphabet lookup and validity functions.
// ----------------------------------------------------------------------------
package rdf_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned SYM_W          = 8;
  localparam int unsigned COUNT_W        = 6;
  localparam int unsigned RADIX_W        = 5;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned NUM_SYMS       = 16;
  localparam int unsigned ALPHA_W        = NUM_SYMS * SYM_W;
  localparam int unsigned HALF_ALPHA_W   = ALPHA_W / 2;
  localparam int unsigned MAX_RADIX_DEF  = 16;
  localparam int unsigned MAX_DIGITS_DEF = 32;

  // Divider: quotient bits resolved per cycle and resulting iteration count.
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_ITERS = VALUE_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

  // Printable range and forbidden sign characters.
  localparam logic [SYM_W-1:0] SYM_MIN   = 8'd32;
  localparam logic [SYM_W-1:0] SYM_MAX   = 8'd126;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  // Register map: 64-bit registers at byte address 8 * index.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_LO = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_HI = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_NEXT,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;         // capture the input value, clear count and flags
    logic set_invalid;  // mark the item as having an invalid alphabet
    logic push_zero;    // store a single zero digit
    logic div_start;    // start one division of the working value
    logic div_take;     // store the remainder digit, keep the quotient
    logic set_rd;       // point the read index at the most significant digit
    logic pop;          // step the read index to the next digit
  } dp_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic val_zero;
    logic div_done;
    logic cnt_full;
    logic rd_last;
  } dp_sts_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                             input logic [DIGIT_W-1:0] idx);
    sym_at = alpha[{idx, 3'b000} +: SYM_W];
  endfunction

  // Alphabet check over the first radix symbols, with the radix itself held
  // to 2..max_radix; symbols beyond the radix are ignored.
  function automatic logic alpha_ok(input logic [RADIX_W-1:0] radix,
                                    input logic [ALPHA_W-1:0] alpha,
                                    input int unsigned max_radix);
    logic             ok;
    logic [SYM_W-1:0] c;
    ok = (radix >= RADIX_W'(2)) && (32'(radix) <= max_radix);
    for (int i = 0; i < NUM_SYMS; i++) begin
      c = alpha[i*SYM_W +: SYM_W];
      if ((i < max_radix) && (i < radix)) begin
        if ((c < SYM_MIN) || (c > SYM_MAX) || (c == SYM_PLUS) || (c == SYM_MINUS)) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if ((j < max_radix) && (j < radix) && (alpha[j*SYM_W +: SYM_W] == c)) begin
            ok = 1'b0;
          end
        end
      end
    end
    alpha_ok = ok;
  endfunction

endpackage
`default_nettype wire

>>> src/rdf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_div - iterative divider of the working value by the radix
// ----------------------------------------------------------------------------
// Restoring division, DIV_BITS quotient bits per cycle. Done pulses for one
// cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module rdf_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rdf_pkg::VALUE_W-1:0]  dividend,
  input  wire logic [rdf_pkg::RADIX_W-1:0]  divisor,
  output logic                              done,
  output logic [rdf_pkg::VALUE_W-1:0]       quotient,
  output logic [rdf_pkg::DIGIT_W-1:0]       remainder
);
  import rdf_pkg::*;

  logic [VALUE_W-1:0]   q_r;
  logic [RADIX_W-1:0]   rem_r;
  logic [RADIX_W-1:0]   dvs_r;
  logic [DIV_CNT_W-1:0] iter_r;
  logic                 busy_r;
  logic                 done_r;

  logic [RADIX_W-1:0]   rem_nxt;
  logic [DIV_BITS-1:0]  qbits;
  logic [RADIX_W-1:0]   shifted;

  // The partial remainder stays below the divisor, so it fits in four bits
  // before each shift.
  always_comb begin
    rem_nxt = rem_r;
    qbits   = '0;
    shifted = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      shifted = {rem_nxt[RADIX_W-2:0], q_r[VALUE_W-1-i]};
      if (shifted >= dvs_r) begin
        qbits[DIV_BITS-1-i] = 1'b1;
        rem_nxt             = shifted - dvs_r;
      end else begin
        rem_nxt = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + DIV_CNT_W'(1);
        if (iter_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[VALUE_W-DIV_BITS-1:0], qbits};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[DIGIT_W-1:0];

endmodule
`default_nettype wire

>>> src/rdf_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_dpath - datapath of the radix digit formatter
// ----------------------------------------------------------------------------
// Working value, divider, digit stack and result payload, all driven by
// commands from the controller.
// ----------------------------------------------------------------------------
module rdf_dpath #(
  parameter int unsigned MAX_RADIX  = rdf_pkg::MAX_RADIX_DEF,
  parameter int unsigned MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rdf_pkg::dp_cmd_t             cmd,
  output rdf_pkg::dp_sts_t                  sts,
  input  wire logic [rdf_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [rdf_pkg::RADIX_W-1:0]  radix,
  input  wire logic [rdf_pkg::ALPHA_W-1:0]  alphabet,
  output logic [rdf_pkg::SYM_W-1:0]         out_symbol,
  output logic                              out_emitted,
  output logic                              out_is_last,
  output logic [rdf_pkg::COUNT_W-1:0]       out_char_count
);
  import rdf_pkg::*;

  localparam int unsigned DIDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [VALUE_W-1:0] val_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [DIDX_W-1:0]  rd_idx_r;
  logic               invalid_r;
  logic [DIGIT_W-1:0] digits_r [MAX_DIGITS];

  logic               div_done;
  logic [VALUE_W-1:0] quot;
  logic [DIGIT_W-1:0] rem;
  logic               rd_last;

  rdf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (val_r),
    .divisor   (radix),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_idx_r  <= '0;
      invalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r     <= '0;
        invalid_r <= 1'b0;
      end else if (cmd.push_zero || cmd.div_take) begin
        cnt_r <= cnt_r + COUNT_W'(1);
      end
      if (cmd.set_invalid) begin
        invalid_r <= 1'b1;
      end
      if (cmd.set_rd) begin
        rd_idx_r <= DIDX_W'(cnt_r - COUNT_W'(1));
      end else if (cmd.pop) begin
        rd_idx_r <= rd_idx_r - DIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value;
    end else if (cmd.div_take) begin
      val_r <= quot;
    end
    if (cmd.push_zero) begin
      digits_r[cnt_r[DIDX_W-1:0]] <= '0;
    end else if (cmd.div_take) begin
      digits_r[cnt_r[DIDX_W-1:0]] <= rem;
    end
  end

  assign rd_last = invalid_r || (rd_idx_r == '0);

  always_comb begin
    sts          = '0;
    sts.alpha_ok = alpha_ok(radix, alphabet, MAX_RADIX);
    sts.val_zero = (val_r == '0);
    sts.div_done = div_done;
    sts.cnt_full = (cnt_r == COUNT_W'(MAX_DIGITS));
    sts.rd_last  = rd_last;
  end

  assign out_symbol     = invalid_r ? '0 : sym_at(alphabet, digits_r[rd_idx_r]);
  assign out_emitted    = !invalid_r;
  assign out_is_last    = rd_last;
  assign out_char_count = rd_last ? cnt_r : '0;

endmodule
`default_nettype wire

>>> src/rdf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdf_ctrl - controller of the radix digit formatter
// ----------------------------------------------------------------------------
// Sequences the alphabet check, the digit divisions and the emission of
// the digits, most significant first.
// ----------------------------------------------------------------------------
module rdf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rdf_pkg::dp_cmd_t       cmd,
  input  wire rdf_pkg::dp_sts_t  sts
);
  import rdf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.alpha_ok) begin
          cmd.set_invalid = 1'b1;
          state_nxt       = ST_EMIT;
        end else if (sts.val_zero) begin
          cmd.push_zero = 1'b1;
          state_nxt     = ST_PREP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.val_zero || sts.cnt_full) begin
          state_nxt = ST_PREP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_PREP: begin
        cmd.set_rd = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.rd_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.pop = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/radix_digit_formatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_formatter - 32-bit unsigned value to digit characters
// ----------------------------------------------------------------------------
// Timing: each digit of a nonzero value costs one pass of the
//   8-bit-per-cycle divider plus a handoff; a zero value skips the
//   divider, and an invalid alphabet goes straight to the output.
// Throughput: one item at a time; a new value is taken only after the
//   final transfer of the previous item.
// Reset: synchronous, active low; returns to idle, configuration cleared.
// ----------------------------------------------------------------------------
// The value is divided repeatedly by the radix; each remainder is pushed on
// a small digit stack, and the stack is then read back from the top so the
// most significant digit goes out first. Each output transfer carries one
// character. The last transfer of an item carries the character count. If
// the alphabet fails its check, a single transfer with no character and a
// count of zero is sent instead.
// ----------------------------------------------------------------------------
module radix_digit_formatter #(
  parameter int unsigned MAX_RADIX  = rdf_pkg::MAX_RADIX_DEF,
  parameter int unsigned MAX_DIGITS = rdf_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rdf_pkg::VALUE_W-1:0]     in_value,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rdf_pkg::SYM_W-1:0]            out_symbol,
  output logic                                 out_emitted,
  output logic                                 out_is_last,
  output logic [rdf_pkg::COUNT_W-1:0]          out_char_count,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [rdf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rdf_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import rdf_pkg::*;

  logic [RADIX_W-1:0]      radix_r;
  logic [HALF_ALPHA_W-1:0] alpha_lo_r;
  logic [HALF_ALPHA_W-1:0] alpha_hi_r;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    cfg_wr;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Registers sit at 8-byte strides; the low address bits are not decoded.
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RADIX:    radix_r    <= pwdata[RADIX_W-1:0];
        REG_ALPHA_LO: alpha_lo_r <= pwdata;
        REG_ALPHA_HI: alpha_hi_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIX:    prdata = CFG_DATA_W'(radix_r);
      REG_ALPHA_LO: prdata = alpha_lo_r;
      REG_ALPHA_HI: prdata = alpha_hi_r;
      default:      prdata = '0;
    endcase
  end

  rdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rdf_dpath #(
    .MAX_RADIX  (MAX_RADIX),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_value),
    .radix          (radix_r),
    .alphabet       ({alpha_hi_r, alpha_lo_r}),
    .out_symbol     (out_symbol),
    .out_emitted    (out_emitted),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

  // After the final transfer of an item the block is ready for the next one.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_is_last) |=> in_ready)
    else $error("not ready after final transfer");

  // An accepted item never produces a result in the following cycle.
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result right after input transfer");

  // A result without a character is the single, final one with zero count.
  a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_emitted) |-> (out_is_last && (out_char_count == '0)))
    else $error("invalid-alphabet result malformed");

  // Only the final result carries a character count.
  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_last) |-> (out_char_count == '0))
    else $error("count on non-final result");

  // The block never takes input while results are being offered.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output active together");

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for radix_digit_formatter
// ----------------------------------------------------------------------------
// Configures radix and alphabet over the register port and streams values
// into the formatter. An independent digit predictor builds the expected
// character transfers, which are checked field by field against the output.
// Covers a directed sweep of the corner cases, then randomized phases with
// idle bursts on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import rdf_pkg::*;

  // Index with no register behind it. A write there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam int STALL_LIMIT     = 3000; // cycles without any transfer
  localparam int HOLD_CYCLES     = 400;  // long output hold-off
  localparam int END_SETTLE      = 240;  // about one 32-digit item
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 21;

  // One expected output transfer.
  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic               emitted;
    logic               is_last;
    logic [COUNT_W-1:0] count;
  } char_exp_t;

  typedef enum logic [0:0] {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_t;

  // One row of the directed sweep. Rows marked known carry a result that
  // is typed in; every other item row goes through the predictor.
  typedef struct packed {
    row_kind_t              kind;
    logic [REG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [VALUE_W-1:0]     value;
    logic                   known;
    char_exp_t              known_res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [VALUE_W-1:0]    in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [SYM_W-1:0]      out_symbol;
  logic                  out_emitted;
  logic                  out_is_last;
  logic [COUNT_W-1:0]    out_char_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Side information that travels with the item on the input channel, so
  // the monitor knows whether to take a typed result or to predict one.
  logic                  item_known;
  char_exp_t             item_known_res;

  // Predictor's copy of the configuration registers.
  logic [RADIX_W-1:0]    cfg_radix;
  logic [ALPHA_W-1:0]    cfg_alpha;

  char_exp_t             pending_chars[$];
  dir_row_t              dir_rows[$];
  int                    fail_count   = 0;
  int                    stall_cycles = 0;
  int                    tx_calm      = 0;
  int                    rx_calm      = 0;
  logic                  quiet_tail   = 1'b0;
  logic                  hold_armed   = 1'b0;

  radix_digit_formatter u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_emitted    (out_emitted),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Length of the next idle burst, drawn at random, with now and then a calm
  // stretch with no idling at all, and none at the end of the run.
  function automatic int burst_len(inout int calm_left, input int odds);
    if (quiet_tail) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if ($urandom_range(0, odds - 1) == 0) return $urandom_range(1, 11);
    return 0;
  endfunction

  // Digit predictor. Checks the alphabet against the current radix, then
  // divides the value down and queues the characters most significant first.
  function automatic void predict_chars(input logic [VALUE_W-1:0] v);
    int                 digs[MAX_DIGITS_DEF];
    int                 n;
    logic [VALUE_W-1:0] rest;
    logic               good;
    logic [SYM_W-1:0]   c;
    char_exp_t          e;
    good = (cfg_radix >= 2) && (cfg_radix <= MAX_RADIX_DEF);
    if (good) begin
      for (int i = 0; i < int'(cfg_radix); i++) begin
        c = cfg_alpha[i*SYM_W +: SYM_W];
        if (c < SYM_MIN || c > SYM_MAX || c == SYM_PLUS || c == SYM_MINUS) good = 1'b0;
        for (int j = i + 1; j < int'(cfg_radix); j++) begin
          if (cfg_alpha[j*SYM_W +: SYM_W] == c) good = 1'b0;
        end
      end
    end
    if (!good) begin
      // A bad alphabet gives a single empty transfer that closes the item.
      e = '{symbol: '0, emitted: 1'b0, is_last: 1'b1, count: '0};
      pending_chars.push_back(e);
      return;
    end
    n = 0;
    rest = v;
    if (rest == 0) begin
      digs[0] = 0;
      n = 1;
    end else begin
      while (rest != 0 && n < MAX_DIGITS_DEF) begin
        digs[n] = int'(rest % cfg_radix);
        rest = rest / cfg_radix;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      e.symbol  = cfg_alpha[digs[n-1-k]*SYM_W +: SYM_W];
      e.emitted = 1'b1;
      e.is_last = (k == n - 1);
      e.count   = e.is_last ? COUNT_W'(n) : '0;
      pending_chars.push_back(e);
    end
  endfunction

  // Builds a 16-symbol alphabet: distinct printable symbols for the radix in
  // use, random bytes beyond it. With corrupt set, one symbol in use is
  // broken in one of the ways the check must catch.
  function automatic logic [ALPHA_W-1:0] make_alphabet(input int unsigned radix,
                                                      input logic corrupt);
    logic [ALPHA_W-1:0] a;
    logic [SYM_W-1:0]   c;
    bit                 taken[256];
    int                 pos;
    a = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < int'(radix) && i < NUM_SYMS; i++) begin
      do c = $urandom_range(SYM_MAX, SYM_MIN);
      while (c == SYM_PLUS || c == SYM_MINUS || taken[c]);
      taken[c] = 1'b1;
      a[i*SYM_W +: SYM_W] = c;
    end
    if (corrupt && radix >= 2 && radix <= NUM_SYMS) begin
      pos = $urandom_range(0, radix - 1);
      case ($urandom_range(0, 4))
        0: a[pos*SYM_W +: SYM_W] = SYM_PLUS;
        1: a[pos*SYM_W +: SYM_W] = SYM_MINUS;
        2: a[pos*SYM_W +: SYM_W] = $urandom_range(0, 31);
        3: a[pos*SYM_W +: SYM_W] = $urandom_range(127, 255);
        default: a[pos*SYM_W +: SYM_W] = a[((pos + 1) % radix)*SYM_W +: SYM_W];
      endcase
    end
    return a;
  endfunction

  // Random value: mostly full-width, sometimes tiny, at the extremes, or at
  // a power of the radix (and one below it) where the digit count steps.
  function automatic logic [VALUE_W-1:0] pick_value(input int unsigned radix);
    logic [63:0] p;
    int unsigned steps;
    int unsigned shape;
    pick_value = $urandom;
    shape = $urandom_range(0, 7);
    if (shape == 0) begin
      pick_value = $urandom_range(0, 1) ? '0 : '1;
    end else if (shape == 1) begin
      pick_value = $urandom_range(0, 300);
    end else if (shape == 2 && radix >= 2 && radix <= NUM_SYMS) begin
      p = 1;
      steps = $urandom_range(1, 32);
      repeat (steps) if (p * radix <= 64'hFFFF_FFFF) p = p * radix;
      pick_value = p[VALUE_W-1:0] - $urandom_range(0, 1);
    end
  endfunction

  function automatic void add_write(input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    dir_rows.push_back('{kind: ROW_WRITE, idx: idx, data: data, value: '0,
                         known: 1'b0, known_res: '0});
  endfunction

  function automatic void add_item(input logic [VALUE_W-1:0] v);
    dir_rows.push_back('{kind: ROW_ITEM, idx: '0, data: '0, value: v,
                         known: 1'b0, known_res: '0});
  endfunction

  // Item whose single result is obvious: either the empty transfer of a bad
  // alphabet (emitted 0) or a lone character for a one-digit value.
  function automatic void add_known(input logic [VALUE_W-1:0] v,
                                    input logic [SYM_W-1:0] sym,
                                    input logic emitted);
    char_exp_t e;
    e = '{symbol: sym, emitted: emitted, is_last: 1'b1,
          count: emitted ? COUNT_W'(1) : COUNT_W'(0)};
    dir_rows.push_back('{kind: ROW_ITEM, idx: '0, data: '0, value: v,
                         known: 1'b1, known_res: e});
  endfunction

  // Offers one value and returns at the falling edge after its transfer.
  // valid stays high into the next item when no gap is drawn.
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic known,
                            input char_exp_t known_res);
    int gap;
    gap = burst_len(tx_calm, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= v;
    item_known     <= known;
    item_known_res <= known_res;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Register write: setup, then access, then idle. The
  // predictor's copy is updated at the edge where the write lands.
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RADIX:    cfg_radix = data[RADIX_W-1:0];
      REG_ALPHA_LO: cfg_alpha[HALF_ALPHA_W-1:0] = data;
      REG_ALPHA_HI: cfg_alpha[ALPHA_W-1:HALF_ALPHA_W] = data;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected character has come out,
  // so the block is idle before the configuration changes.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  // Output side. Ready changes on the falling edge. Besides the short
  // bursts, one long hold-off is taken when the stimulus arms it, so the
  // formatter backs up and has to stall its input.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        gap = burst_len(rx_calm, 8);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor, on the rising edge. Output transfers are checked before the
  // new input's predictions are queued; no item's result can come out in
  // the same cycle it goes in. The watchdog counts cycles with no transfer
  // on either channel.
  always @(posedge clk) begin : monitor
    char_exp_t want;
    if (rst_n) begin
      stall_cycles = stall_cycles + 1;
      if (out_valid && out_ready) begin
        stall_cycles = 0;
        if (pending_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result: symbol %02h emitted %0b last %0b count %0d",
                     out_symbol, out_emitted, out_is_last, out_char_count);
          end
        end else begin
          want = pending_chars.pop_front();
          if (out_symbol !== want.symbol || out_emitted !== want.emitted ||
              out_is_last !== want.is_last || out_char_count !== want.count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch: expected symbol %02h emitted %0b last %0b count %0d, %s",
                       want.symbol, want.emitted, want.is_last, want.count, "got");
              $display("          actual   symbol %02h emitted %0b last %0b count %0d",
                       out_symbol, out_emitted, out_is_last, out_char_count);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        stall_cycles = 0;
        if (item_known) pending_chars.push_back(item_known_res);
        else predict_chars(in_value);
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned      ph_radix;
    int unsigned      mode;
    logic [ALPHA_W-1:0] ph_alpha;
    logic [CFG_DATA_W-1:0] radix_word;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    item_known     = 1'b0;
    item_known_res = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_radix      = '0;
    cfg_alpha      = '0;

    // Directed sweep. Registers come out of reset at zero, so the alphabet
    // starts out invalid.
    add_known(32'h0000_0000, 8'h00, 1'b0);
    add_known(32'hFFFF_FFFF, 8'h00, 1'b0);
    // A radix of one is still invalid.
    add_write(REG_RADIX, 64'd1);
    add_known(32'd5, 8'h00, 1'b0);
    // Plain hexadecimal, symbol 0 in the low byte of the low word.
    add_write(REG_ALPHA_LO, "76543210");
    add_write(REG_ALPHA_HI, "FEDCBA98");
    add_write(REG_RADIX, 64'd16);
    add_known(32'h0000_0000, "0", 1'b1);
    add_item(32'hFFFF_FFFF);
    add_item(32'h1234_5678);
    // Binary reaches the full 32 digits.
    add_write(REG_RADIX, 64'd2);
    add_item(32'hFFFF_FFFF);
    add_item(32'h8000_0000);
    add_known(32'd1, "1", 1'b1);
    // Radix above the supported maximum, including the largest code.
    add_write(REG_RADIX, 64'd17);
    add_known(32'd9, 8'h00, 1'b0);
    add_write(REG_RADIX, 64'd31);
    add_known(32'd9, 8'h00, 1'b0);
    // Radix three: symbols past the radix hold junk (signs, duplicates,
    // non-printables) that must not be looked at.
    add_write(REG_ALPHA_LO, 64'hFF2B_2D00_007A_7921);
    add_write(REG_RADIX, 64'd3);
    add_item(32'd7);
    add_known(32'd0, 8'h21, 1'b1);
    // A write to the unmapped index must leave radix three in place.
    add_write(REG_UNMAPPED, 64'd0);
    add_item(32'd100);
    // Radix nine reaches into the high word, whose first symbol is DEL.
    add_write(REG_ALPHA_LO, "HGFEDCBA");
    add_write(REG_ALPHA_HI, 64'h0000_0000_0000_007F);
    add_write(REG_RADIX, 64'd9);
    add_known(32'd123, 8'h00, 1'b0);
    // Space and tilde are the printable extremes and are legal.
    add_write(REG_ALPHA_HI, 64'h0000_0000_0000_7E20);
    add_write(REG_RADIX, 64'd10);
    add_item(32'hFFFF_FFFF);
    add_known(32'd0, "A", 1'b1);
    // Plus sign, minus sign, a control code and a duplicate each spoil it.
    add_write(REG_ALPHA_HI, 64'h0000_0000_0000_7E2B);
    add_known(32'd42, 8'h00, 1'b0);
    add_write(REG_ALPHA_HI, 64'h0000_0000_0000_7E2D);
    add_known(32'd42, 8'h00, 1'b0);
    add_write(REG_ALPHA_HI, 64'h0000_0000_0000_7E1F);
    add_known(32'd42, 8'h00, 1'b0);
    add_write(REG_ALPHA_HI, 64'h0000_0000_0000_7E41);
    add_known(32'd42, 8'h00, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        drain_results();
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_value(dir_rows[r].value, dir_rows[r].known, dir_rows[r].known_res);
      end
    end

    // Random phases. The first two pin the radix extremes; later ones mix in
    // bad radix codes and broken alphabets. The last two run without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      mode = $urandom_range(0, 9);
      if (p == 0) ph_radix = 2;
      else if (p == 1) ph_radix = 16;
      else if (mode == 0) ph_radix = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                          : $urandom_range(17, 31);
      else ph_radix = $urandom_range(2, 16);
      ph_alpha = make_alphabet(ph_radix, (p > 1) && (mode == 1));
      // Upper bits of the radix word are random; only the low five count.
      radix_word = {$urandom, $urandom};
      radix_word[RADIX_W-1:0] = ph_radix[RADIX_W-1:0];
      cfg_write(REG_ALPHA_HI, ph_alpha[ALPHA_W-1:HALF_ALPHA_W]);
      cfg_write(REG_ALPHA_LO, ph_alpha[HALF_ALPHA_W-1:0]);
      cfg_write(REG_RADIX, radix_word);
      if (p >= NUM_PHASES - 2) quiet_tail = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_value(pick_value(ph_radix), 1'b0, '0);
        // Early in one phase, freeze the output while inputs keep
        // coming.
        if (p == 3 && i == 2) hold_armed = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    // Let a full item's worth of cycles pass to catch any stray output.
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
